// ----- hw/rtl/prime_test_and_nth_prime_defines.svh -----
`ifndef PRIME_TEST_AND_NTH_PRIME_DEFINES_SVH
`define PRIME_TEST_AND_NTH_PRIME_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define PTNP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTNP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ptnp_pkg.sv -----
package ptnp_pkg;

    localparam int unsigned VALUE_BITS   = 16;
    localparam int unsigned TABLE_DEPTH  = 8192;
    localparam int unsigned OPERAND_BITS = 16;
    localparam int unsigned DIV_BITS     = (VALUE_BITS + 1) / 2 + 1;
    localparam int unsigned SQ_BITS      = 2 * DIV_BITS;
    localparam int unsigned ADDR_BITS    = $clog2(TABLE_DEPTH);
    localparam int unsigned COUNT_BITS   = ADDR_BITS + 1;
    localparam int unsigned CAND_BITS    = VALUE_BITS + 1;

    localparam logic FUNC_TEST = 1'b0;
    localparam logic FUNC_NTH  = 1'b1;

    typedef struct packed {
        logic                  valid;
        logic [VALUE_BITS-1:0] num;
        logic [DIV_BITS-1:0]   div;
        logic [DIV_BITS-1:0]   rem;
    } t_cell;

endpackage

// ----- hw/rtl/ptnp_ram.sv -----
module ptnp_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/ptnp_cell.sv -----
module ptnp_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ptnp_pkg::t_cell  i_cell,
    output ptnp_pkg::t_cell  o_cell
);

    logic [ptnp_pkg::DIV_BITS:0]     shifted;
    logic [ptnp_pkg::DIV_BITS:0]     diff;
    logic [ptnp_pkg::DIV_BITS-1:0]   n_rem;
    logic                            r_valid;
    logic [ptnp_pkg::VALUE_BITS-1:0] r_num;
    logic [ptnp_pkg::DIV_BITS-1:0]   r_div;
    logic [ptnp_pkg::DIV_BITS-1:0]   r_rem;

    always_comb begin
        shifted = {i_cell.rem, i_cell.num[ptnp_pkg::VALUE_BITS-1]};
        diff    = shifted - {1'b0, i_cell.div};
        if (shifted >= {1'b0, i_cell.div}) begin
            n_rem = diff[ptnp_pkg::DIV_BITS-1:0];
        end else begin
            n_rem = shifted[ptnp_pkg::DIV_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= {i_cell.num[ptnp_pkg::VALUE_BITS-2:0], 1'b0};
        r_div <= i_cell.div;
        r_rem <= n_rem;
    end

    always_comb begin
        o_cell.valid = r_valid;
        o_cell.num   = r_num;
        o_cell.div   = r_div;
        o_cell.rem   = r_rem;
    end

endmodule

// ----- hw/rtl/ptnp_chain.sv -----
module ptnp_chain (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ptnp_pkg::t_cell  i_issue,
    output ptnp_pkg::t_cell  o_result,
    output logic             o_active
);

    ptnp_pkg::t_cell links [ptnp_pkg::VALUE_BITS+1];

    assign links[0] = i_issue;

    for (genvar g = 0; g < ptnp_pkg::VALUE_BITS; g++) begin : g_cell
        ptnp_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cell (links[g]),
            .o_cell (links[g+1])
        );
    end

    always_comb begin
        o_active = 1'b0;
        for (int k = 1; k <= ptnp_pkg::VALUE_BITS; k++) begin
            o_active = o_active | links[k].valid;
        end
    end

    assign o_result = links[ptnp_pkg::VALUE_BITS];

endmodule

// ----- hw/rtl/prime_test_and_nth_prime.sv -----
// Prime test: inputs below 3 or even are answered straight from idle; odd n sends
// one divisor per cycle into the cell chain until past sqrt(n) or a zero remainder,
// then waits for its drain. Nth prime: index 0, 1 or beyond the table is answered
// straight from idle; else 2 is seeded on first use, new odd candidates are tested, then the table is read.
// One item at a time; the result strobe lasts one cycle and cannot be stalled.
// Synchronous active-low reset clears control and the prime count; no clearing pass.
module prime_test_and_nth_prime (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_func,
    input  logic [ptnp_pkg::OPERAND_BITS-1:0] i_operand,
    output logic                              o_strobe,
    output logic                              o_is_prime,
    output logic [ptnp_pkg::OPERAND_BITS-1:0] o_prime_value,
    output logic                              o_out_of_range
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_TEST   = 5'b00010,
        S_SEARCH = 5'b00100,
        S_LOOKUP = 5'b01000,
        S_FETCH  = 5'b10000
    } t_state;

    t_state                            r_state, n_state;
    logic                              r_func, n_func;
    logic [ptnp_pkg::VALUE_BITS-1:0]   r_num, n_num;
    logic [ptnp_pkg::DIV_BITS-1:0]     r_div, n_div;
    logic                              r_stop, n_stop;
    logic                              r_comp, n_comp;
    logic [ptnp_pkg::OPERAND_BITS-1:0] r_idx, n_idx;
    logic [ptnp_pkg::CAND_BITS-1:0]    r_cand, n_cand;
    logic [ptnp_pkg::COUNT_BITS-1:0]   r_pf, n_pf;
    logic                              r_strobe, n_strobe;
    logic                              r_is_prime, n_is_prime;
    logic [ptnp_pkg::OPERAND_BITS-1:0] r_value, n_value;
    logic                              r_oor, n_oor;

    logic [ptnp_pkg::SQ_BITS-1:0]      sq;
    logic                              past_root;
    ptnp_pkg::t_cell                   issue;
    ptnp_pkg::t_cell                   result;
    logic                              active;

    logic                              wr_en;
    logic [ptnp_pkg::ADDR_BITS-1:0]    wr_addr;
    logic [ptnp_pkg::VALUE_BITS-1:0]   wr_data;
    logic [ptnp_pkg::ADDR_BITS-1:0]    rd_addr;
    logic [ptnp_pkg::VALUE_BITS-1:0]   rd_data;

    assign sq        = ptnp_pkg::SQ_BITS'(r_div) * ptnp_pkg::SQ_BITS'(r_div);
    assign past_root = sq > ptnp_pkg::SQ_BITS'(r_num);

    always_comb begin
        issue.valid = (r_state == S_TEST) && !r_stop && !past_root;
        issue.num   = r_num;
        issue.div   = r_div;
        issue.rem   = '0;
    end

    ptnp_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (issue),
        .o_result(result),
        .o_active(active)
    );

    ptnp_ram #(
        .WIDTH(ptnp_pkg::VALUE_BITS),
        .DEPTH(ptnp_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_num      = r_num;
        n_div      = r_div;
        n_stop     = r_stop;
        n_comp     = r_comp;
        n_idx      = r_idx;
        n_cand     = r_cand;
        n_pf       = r_pf;
        n_strobe   = 1'b0;
        n_is_prime = r_is_prime;
        n_value    = r_value;
        n_oor      = r_oor;
        wr_en      = 1'b0;
        wr_addr    = r_pf[ptnp_pkg::ADDR_BITS-1:0];
        wr_data    = r_cand[ptnp_pkg::VALUE_BITS-1:0];
        rd_addr    = ptnp_pkg::ADDR_BITS'(r_idx - ptnp_pkg::OPERAND_BITS'(1));
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func = i_func;
                    n_idx  = i_operand;
                    if (i_func == ptnp_pkg::FUNC_TEST) begin
                        if (i_operand == ptnp_pkg::OPERAND_BITS'(2)) begin
                            n_strobe   = 1'b1;
                            n_is_prime = 1'b1;
                            n_value    = '0;
                            n_oor      = 1'b0;
                        end else if (i_operand < ptnp_pkg::OPERAND_BITS'(2) || !i_operand[0]) begin
                            n_strobe   = 1'b1;
                            n_is_prime = 1'b0;
                            n_value    = '0;
                            n_oor      = 1'b0;
                        end else begin
                            n_num   = ptnp_pkg::VALUE_BITS'(i_operand);
                            n_div   = ptnp_pkg::DIV_BITS'(3);
                            n_stop  = 1'b0;
                            n_comp  = 1'b0;
                            n_state = S_TEST;
                        end
                    end else begin
                        if (i_operand <= ptnp_pkg::OPERAND_BITS'(1)) begin
                            n_strobe   = 1'b1;
                            n_is_prime = 1'b0;
                            n_value    = ptnp_pkg::OPERAND_BITS'(2);
                            n_oor      = 1'b0;
                        end else if (32'(i_operand) > ptnp_pkg::TABLE_DEPTH) begin
                            n_strobe   = 1'b1;
                            n_is_prime = 1'b0;
                            n_value    = '0;
                            n_oor      = 1'b1;
                        end else begin
                            n_state = S_SEARCH;
                        end
                    end
                end
            end
            S_TEST: begin
                if (!r_stop) begin
                    if (past_root) begin
                        n_stop = 1'b1;
                    end else begin
                        n_div = r_div + ptnp_pkg::DIV_BITS'(2);
                    end
                end
                if (result.valid && result.rem == '0) begin
                    n_comp = 1'b1;
                    n_stop = 1'b1;
                end
                if (r_stop && !active) begin
                    if (r_func == ptnp_pkg::FUNC_TEST) begin
                        n_strobe   = 1'b1;
                        n_is_prime = !r_comp;
                        n_value    = '0;
                        n_oor      = 1'b0;
                        n_state    = S_IDLE;
                    end else begin
                        if (!r_comp) begin
                            wr_en = 1'b1;
                            n_pf  = r_pf + ptnp_pkg::COUNT_BITS'(1);
                        end
                        n_cand  = r_cand + ptnp_pkg::CAND_BITS'(2);
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (r_pf == '0) begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = ptnp_pkg::VALUE_BITS'(2);
                    n_pf    = ptnp_pkg::COUNT_BITS'(1);
                    n_cand  = ptnp_pkg::CAND_BITS'(3);
                end else if (32'(r_pf) >= 32'(r_idx)) begin
                    n_state = S_LOOKUP;
                end else if (r_cand[ptnp_pkg::VALUE_BITS]) begin
                    n_strobe   = 1'b1;
                    n_is_prime = 1'b0;
                    n_value    = '0;
                    n_oor      = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_num   = r_cand[ptnp_pkg::VALUE_BITS-1:0];
                    n_div   = ptnp_pkg::DIV_BITS'(3);
                    n_stop  = 1'b0;
                    n_comp  = 1'b0;
                    n_state = S_TEST;
                end
            end
            S_LOOKUP: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                n_strobe   = 1'b1;
                n_is_prime = 1'b0;
                n_value    = ptnp_pkg::OPERAND_BITS'(rd_data);
                n_oor      = 1'b0;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_cand   <= '0;
            r_pf     <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_cand   <= n_cand;
            r_pf     <= n_pf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_num      <= n_num;
        r_div      <= n_div;
        r_stop     <= n_stop;
        r_comp     <= n_comp;
        r_idx      <= n_idx;
        r_is_prime <= n_is_prime;
        r_value    <= n_value;
        r_oor      <= n_oor;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_is_prime     = r_is_prime;
    assign o_prime_value  = r_value;
    assign o_out_of_range = r_oor;

endmodule

// ----- hw/rtl/ptnp_checker.sv -----
`include "prime_test_and_nth_prime_defines.svh"

module ptnp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_strobe,
    input logic                              o_is_prime,
    input logic [ptnp_pkg::OPERAND_BITS-1:0] o_prime_value,
    input logic                              o_out_of_range
);

    `PTNP_ASSERT_NEXT(a_accept_answered, i_clk, i_rst_n, start && !busy, busy || o_strobe, "item accepted but neither busy nor answered")
    `PTNP_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "result strobed while busy")
    `PTNP_ASSERT_NOW(a_oor_clean, i_clk, i_rst_n, o_strobe && o_out_of_range, o_prime_value == '0 && !o_is_prime, "out-of-range result carries data")
    `PTNP_ASSERT_NOW(a_done_strobes, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n), o_strobe, "busy dropped without a result")

endmodule

bind prime_test_and_nth_prime ptnp_checker u_ptnp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_is_prime    (o_is_prime),
    .o_prime_value (o_prime_value),
    .o_out_of_range(o_out_of_range)
);

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT   = 20_000_000;
    localparam int DRAIN_CYCLES     = 400;
    localparam int RANDOM_PER_PHASE = 39;
    localparam longint unsigned VALUE_MAX = (64'd1 << ptnp_pkg::VALUE_BITS) - 64'd1;

    typedef struct packed {
        logic                              is_prime;
        logic [ptnp_pkg::OPERAND_BITS-1:0] value;
        logic                              out_of_range;
    } t_prime_answer;

    typedef struct packed {
        logic                              func;
        logic [ptnp_pkg::OPERAND_BITS-1:0] operand;
        logic                              typed;
        t_prime_answer                     answer;
    } t_query_row;

    localparam t_query_row DIRECTED[24] = '{
        '{ptnp_pkg::FUNC_TEST, 16'd0,     1'b1, '{1'b0, 16'd0,     1'b0}},
        '{ptnp_pkg::FUNC_TEST, 16'd1,     1'b1, '{1'b0, 16'd0,     1'b0}},
        '{ptnp_pkg::FUNC_TEST, 16'd2,     1'b1, '{1'b1, 16'd0,     1'b0}},
        '{ptnp_pkg::FUNC_TEST, 16'd3,     1'b1, '{1'b1, 16'd0,     1'b0}},
        '{ptnp_pkg::FUNC_TEST, 16'd4,     1'b1, '{1'b0, 16'd0,     1'b0}},
        '{ptnp_pkg::FUNC_TEST, 16'd9,     1'b0, '0},
        '{ptnp_pkg::FUNC_TEST, 16'd63001, 1'b0, '0},
        '{ptnp_pkg::FUNC_TEST, 16'd65521, 1'b1, '{1'b1, 16'd0,     1'b0}},
        '{ptnp_pkg::FUNC_TEST, 16'd65535, 1'b1, '{1'b0, 16'd0,     1'b0}},
        '{ptnp_pkg::FUNC_TEST, 16'd65534, 1'b1, '{1'b0, 16'd0,     1'b0}},
        '{ptnp_pkg::FUNC_NTH,  16'd0,     1'b1, '{1'b0, 16'd2,     1'b0}},
        '{ptnp_pkg::FUNC_NTH,  16'd1,     1'b1, '{1'b0, 16'd2,     1'b0}},
        '{ptnp_pkg::FUNC_NTH,  16'd8193,  1'b1, '{1'b0, 16'd0,     1'b1}},
        '{ptnp_pkg::FUNC_NTH,  16'd2,     1'b0, '0},
        '{ptnp_pkg::FUNC_NTH,  16'd3,     1'b0, '0},
        '{ptnp_pkg::FUNC_NTH,  16'd10,    1'b0, '0},
        '{ptnp_pkg::FUNC_NTH,  16'd100,   1'b0, '0},
        '{ptnp_pkg::FUNC_NTH,  16'd50,    1'b0, '0},
        '{ptnp_pkg::FUNC_NTH,  16'd1000,  1'b0, '0},
        '{ptnp_pkg::FUNC_NTH,  16'd65535, 1'b1, '{1'b0, 16'd0,     1'b1}},
        '{ptnp_pkg::FUNC_NTH,  16'd6542,  1'b1, '{1'b0, 16'd65521, 1'b0}},
        '{ptnp_pkg::FUNC_NTH,  16'd6543,  1'b1, '{1'b0, 16'd0,     1'b1}},
        '{ptnp_pkg::FUNC_NTH,  16'd8192,  1'b1, '{1'b0, 16'd0,     1'b1}},
        '{ptnp_pkg::FUNC_NTH,  16'd6541,  1'b0, '0}
    };

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic                              i_func;
    logic [ptnp_pkg::OPERAND_BITS-1:0] i_operand;
    logic                              o_strobe;
    logic                              o_is_prime;
    logic [ptnp_pkg::OPERAND_BITS-1:0] o_prime_value;
    logic                              o_out_of_range;

    t_prime_answer   pending_answers[$];
    t_prime_answer   oldest_answer;
    int unsigned     known_primes[ptnp_pkg::TABLE_DEPTH];
    int unsigned     primes_known = 0;
    longint unsigned next_candidate = 0;
    int              mismatches = 0;
    int              quiet_cycles = 0;
    int              primality_queries = 0;
    int              primes_reported = 0;
    int              nth_queries = 0;
    int              overflow_answers = 0;
    int              idle_plan[3] = '{10, 67, 0};

    prime_test_and_nth_prime i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_operand      (i_operand),
        .o_strobe       (o_strobe),
        .o_is_prime     (o_is_prime),
        .o_prime_value  (o_prime_value),
        .o_out_of_range (o_out_of_range)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit has_known_factor(longint unsigned cand);
        longint unsigned p;
        for (int unsigned k = 0; k < primes_known; k++) begin
            p = known_primes[k];
            if (p * p > cand)
                return 1'b0;
            if (cand % p == 0)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_prime_answer predict_answer(logic func,
                                                     logic [ptnp_pkg::OPERAND_BITS-1:0] operand);
        t_prime_answer answer;
        int unsigned   n;
        int unsigned   d;
        answer = '0;
        n = 32'(operand);
        if (func == ptnp_pkg::FUNC_TEST) begin
            if (n == 2) begin
                answer.is_prime = 1'b1;
            end else if (n >= 3 && n[0]) begin
                answer.is_prime = 1'b1;
                for (d = 3; d * d <= n && answer.is_prime; d += 2)
                    if (n % d == 0)
                        answer.is_prime = 1'b0;
            end
        end else if (n <= 1) begin
            answer.value = ptnp_pkg::OPERAND_BITS'(2);
        end else if (n > ptnp_pkg::TABLE_DEPTH) begin
            answer.out_of_range = 1'b1;
        end else begin
            if (primes_known == 0) begin
                known_primes[0] = 2;
                primes_known = 1;
                next_candidate = 3;
            end
            while (primes_known < n && next_candidate <= VALUE_MAX) begin
                if (!has_known_factor(next_candidate)) begin
                    known_primes[primes_known] = 32'(next_candidate);
                    primes_known++;
                end
                next_candidate += 2;
            end
            if (primes_known < n)
                answer.out_of_range = 1'b1;
            else
                answer.value = ptnp_pkg::OPERAND_BITS'(known_primes[n-1]);
        end
        return answer;
    endfunction

    function automatic t_query_row make_random_query();
        t_query_row  row;
        int unsigned root;
        row = '0;
        row.func = 1'($urandom_range(1));
        if (row.func == ptnp_pkg::FUNC_TEST) begin
            case ($urandom_range(3))
                0: row.operand = ptnp_pkg::OPERAND_BITS'($urandom_range(64));
                1: row.operand = ptnp_pkg::OPERAND_BITS'($urandom_range(65535));
                2: row.operand = ptnp_pkg::OPERAND_BITS'($urandom_range(65535) | 1);
                default: begin
                    root = $urandom_range(255, 3) | 1;
                    row.operand = ptnp_pkg::OPERAND_BITS'(root * root);
                end
            endcase
        end else begin
            case ($urandom_range(3))
                0: row.operand = ptnp_pkg::OPERAND_BITS'($urandom_range(30));
                1: row.operand = ptnp_pkg::OPERAND_BITS'($urandom_range(ptnp_pkg::TABLE_DEPTH));
                2: row.operand = ptnp_pkg::OPERAND_BITS'($urandom_range(6548, 6536));
                default: row.operand = ptnp_pkg::OPERAND_BITS'(
                             $urandom_range(65535, ptnp_pkg::TABLE_DEPTH - 2));
            endcase
        end
        return row;
    endfunction

    task automatic issue_query(input t_query_row row, input int idle_pct);
        t_prime_answer want;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_func    <= row.func;
        i_operand <= row.operand;
        do @(posedge i_clk); while (busy);
        want = predict_answer(row.func, row.operand);
        if (row.typed)
            want = row.answer;
        pending_answers.push_back(want);
        if (row.func == ptnp_pkg::FUNC_TEST) begin
            primality_queries++;
            primes_reported += int'(want.is_prime);
        end else begin
            nth_queries++;
            overflow_answers += int'(want.out_of_range);
        end
    endtask

    task automatic wait_for_answers();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_answers.size() == 0) begin
                $error("result with no item outstanding");
                mismatches++;
            end else begin
                oldest_answer = pending_answers.pop_front();
                if (o_is_prime !== oldest_answer.is_prime) begin
                    $error("is_prime: expected %0d, got %0d", oldest_answer.is_prime, o_is_prime);
                    mismatches++;
                end
                if (o_prime_value !== oldest_answer.value) begin
                    $error("prime_value: expected %0d, got %0d",
                           oldest_answer.value, o_prime_value);
                    mismatches++;
                end
                if (o_out_of_range !== oldest_answer.out_of_range) begin
                    $error("out_of_range: expected %0d, got %0d",
                           oldest_answer.out_of_range, o_out_of_range);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        start     <= 1'b0;
        i_func    <= ptnp_pkg::FUNC_TEST;
        i_operand <= '0;
        i_rst_n   <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < $size(DIRECTED); k++)
            issue_query(DIRECTED[k], idle_plan[0]);
        wait_for_answers();

        foreach (idle_plan[ph]) begin
            repeat (RANDOM_PER_PHASE)
                issue_query(make_random_query(), idle_plan[ph]);
            wait_for_answers();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_answers.size() != 0) begin
            $error("%0d results never arrived", pending_answers.size());
            mismatches++;
        end

        $display("Covered %0d primality tests (%0d prime) and %0d nth-prime requests",
                 primality_queries, primes_reported, nth_queries);
        $display("%0d overflow answers; prime list built up to %0d entries; gaps 10, 67, 0 pct",
                 overflow_answers, primes_known);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ptnp_pkg.sv
hw/rtl/ptnp_ram.sv
hw/rtl/ptnp_cell.sv
hw/rtl/ptnp_chain.sv
hw/rtl/prime_test_and_nth_prime.sv
hw/rtl/ptnp_checker.sv
tb/testbench.sv
